@@ rtl/core/qau_pkg.sv @@
package qau_pkg;

    // Fixed-point format of every quaternion component.
    localparam int FRAC_BITS = 12;
    localparam int DW        = 16;

    // Sum of four products, and squared magnitude.
    localparam int PW        = 2 * DW + 2;
    localparam int SW        = 2 * DW + 1;

    // The magnitude carries this many extra fraction bits during normalization.
    localparam int EXT       = 8;

    // Square root: radicand padded to an even width, one root bit per stage.
    localparam int XPW       = ((SW + 2 * EXT + 1) / 2) * 2;
    localparam int RT_STEPS  = XPW / 2;
    localparam int RTW       = RT_STEPS;
    localparam int RMW       = RTW + 3;

    // Division: quotient bits produced, numerator width, compare width.
    localparam int DQB       = DW + 1;
    localparam int NW        = DW + 2 * FRAC_BITS + 1;
    localparam int CW        = (NW - DQB > SW) ? NW - DQB : SW;

    localparam logic [2:0] OP_MUL = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_NEG = 3'd2;
    localparam logic [2:0] OP_NRM = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_INV0 = 2'd2;

    localparam logic signed [PW-1:0] SMAX = PW'((1 << (DW - 1)) - 1);
    localparam logic signed [PW-1:0] SMIN = ~SMAX;
    localparam logic [DW-1:0]        RMAX = SMAX[DW-1:0];
    localparam logic [DW-1:0]        RMIN = SMIN[DW-1:0];
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic                 vld;
        logic [2:0]           op;
        logic [3:0][DW-1:0]   a;
        logic [3:0][DW-1:0]   b;
    } t_in;

    typedef struct packed {
        logic                      vld;
        logic [2:0]                op;
        logic [3:0][DW-1:0]        a;
        logic [3:0][DW-1:0]        b;
        logic [3:0][3:0][2*DW-1:0] p;
        logic [3:0][2*DW-1:0]      sq;
    } t_stb;

    typedef struct packed {
        logic                 vld;
        logic [2:0]           op;
        logic [3:0]           neg;
        logic [3:0][DW-1:0]   mag;
        logic [SW-1:0]        s;
        logic [3:0][DW-1:0]   res;
        logic [1:0]           st;
    } t_car;

    typedef struct packed {
        t_car                 c;
        logic [3:0][PW-1:0]   ps;
    } t_stc;

    typedef struct packed {
        t_car                 c;
        logic [RMW-1:0]       rem;
        logic [RTW-1:0]       root;
    } t_sqs;

    typedef struct packed {
        t_car                 c;
        logic [3:0][SW-1:0]   rem;
        logic [3:0][DQB-1:0]  q;
        logic [3:0][DQB-1:0]  low;
        logic [3:0]           ovf;
        logic [SW-1:0]        d;
    } t_dvs;

    function automatic logic signed [2*DW-1:0] smul(input logic signed [DW-1:0] x,
                                                    input logic signed [DW-1:0] y);
        return (2 * DW)'(x) * (2 * DW)'(y);
    endfunction

    function automatic logic signed [PW-1:0] pext(input logic [2*DW-1:0] p);
        return PW'($signed(p));
    endfunction

    // Returns the saturation flag above the clamped component.
    function automatic logic [DW:0] sat(input logic signed [PW-1:0] v);
        logic [DW:0] r;
        if (v > SMAX) begin
            r = {1'b1, RMAX};
        end else if (v < SMIN) begin
            r = {1'b1, RMIN};
        end else begin
            r = {1'b0, v[DW-1:0]};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/quaternion_arithmetic_unit.sv @@
// Channel | Signals                                         | Direction
// input   | i_valid, o_stall, i_operation, i_a_*, i_b_*     | into the unit
// output  | o_valid, i_stall, o_r_w/x/y/z, o_status         | out of the unit
//
// One transaction is accepted every cycle while the output is not stalled. Each
// result passes through the square-root chain (one root bit per stage) followed
// by the restoring division chain (one quotient bit per stage); this path does not
// depend on the operation. Reset is synchronous and clears all valid bits.
// A stall on the output freezes every stage at once, so nothing is lost or
// repeated; o_stall is high only while a finished result waits to be taken.

module quaternion_arithmetic_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_operation,
    input  logic signed [qau_pkg::DW-1:0]     i_a_w,
    input  logic signed [qau_pkg::DW-1:0]     i_a_x,
    input  logic signed [qau_pkg::DW-1:0]     i_a_y,
    input  logic signed [qau_pkg::DW-1:0]     i_a_z,
    input  logic signed [qau_pkg::DW-1:0]     i_b_w,
    input  logic signed [qau_pkg::DW-1:0]     i_b_x,
    input  logic signed [qau_pkg::DW-1:0]     i_b_y,
    input  logic signed [qau_pkg::DW-1:0]     i_b_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [qau_pkg::DW-1:0]     o_r_w,
    output logic signed [qau_pkg::DW-1:0]     o_r_x,
    output logic signed [qau_pkg::DW-1:0]     o_r_y,
    output logic signed [qau_pkg::DW-1:0]     o_r_z,
    output logic [1:0]                        o_status
);

    // Global advance: the whole pipe moves unless a held result is stalled.
    logic en;

    qau_pkg::t_in  r_a, n_a;
    qau_pkg::t_stb r_b, n_b;
    qau_pkg::t_stc r_c, n_c;
    qau_pkg::t_sqs r_sq [qau_pkg::RT_STEPS+1];
    qau_pkg::t_sqs n_d;
    qau_pkg::t_dvs r_dv [qau_pkg::DQB+1];
    qau_pkg::t_dvs n_p;

    logic                             r_out_vld, n_out_vld;
    logic [3:0][qau_pkg::DW-1:0]      r_out_res, n_out_res;
    logic [1:0]                       r_out_st, n_out_st;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    // Stage A: register the incoming transaction. Index 0 is w, then x, y, z.
    always_comb begin
        n_a.vld  = i_valid;
        n_a.op   = i_operation;
        n_a.a[0] = i_a_w;
        n_a.a[1] = i_a_x;
        n_a.a[2] = i_a_y;
        n_a.a[3] = i_a_z;
        n_a.b[0] = i_b_w;
        n_a.b[1] = i_b_x;
        n_a.b[2] = i_b_y;
        n_a.b[3] = i_b_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else if (en) begin
            r_a <= n_a;
        end
    end

    // Stage B: all sixteen cross products and the four squares, one multiplier each.
    always_comb begin
        n_b     = '0;
        n_b.vld = r_a.vld;
        n_b.op  = r_a.op;
        n_b.a   = r_a.a;
        n_b.b   = r_a.b;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_b.p[i][j] = qau_pkg::smul($signed(r_a.a[i]), $signed(r_a.b[j]));
            end
            n_b.sq[i] = qau_pkg::smul($signed(r_a.a[i]), $signed(r_a.a[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (en) begin
            r_b <= n_b;
        end
    end

    // Stage C: Hamilton sums, squared magnitude, and the finished sum and negation.
    always_comb begin
        logic signed [qau_pkg::DW-1:0] av;
        logic signed [qau_pkg::DW-1:0] bv;
        logic [qau_pkg::DW:0]          sr;
        logic                          satany;

        n_c       = '0;
        n_c.c.vld = r_b.vld;
        n_c.c.op  = r_b.op;
        satany    = 1'b0;

        n_c.ps[0] = qau_pkg::pext(r_b.p[0][0]) - qau_pkg::pext(r_b.p[1][1])
                  - qau_pkg::pext(r_b.p[2][2]) - qau_pkg::pext(r_b.p[3][3]);
        n_c.ps[1] = qau_pkg::pext(r_b.p[0][1]) + qau_pkg::pext(r_b.p[1][0])
                  + qau_pkg::pext(r_b.p[2][3]) - qau_pkg::pext(r_b.p[3][2]);
        n_c.ps[2] = qau_pkg::pext(r_b.p[0][2]) - qau_pkg::pext(r_b.p[1][3])
                  + qau_pkg::pext(r_b.p[2][0]) + qau_pkg::pext(r_b.p[3][1]);
        n_c.ps[3] = qau_pkg::pext(r_b.p[0][3]) + qau_pkg::pext(r_b.p[1][2])
                  - qau_pkg::pext(r_b.p[2][1]) + qau_pkg::pext(r_b.p[3][0]);

        n_c.c.s = qau_pkg::SW'(r_b.sq[0]) + qau_pkg::SW'(r_b.sq[1])
                + qau_pkg::SW'(r_b.sq[2]) + qau_pkg::SW'(r_b.sq[3]);

        for (int i = 0; i < 4; i++) begin
            av = $signed(r_b.a[i]);
            bv = $signed(r_b.b[i]);
            n_c.c.mag[i] = av[qau_pkg::DW-1] ? qau_pkg::DW'(-av) : qau_pkg::DW'(av);
            // The inverse works on the conjugate, whose vector part flips sign.
            if (r_b.op == qau_pkg::OP_INV && i != 0) begin
                n_c.c.neg[i] = !av[qau_pkg::DW-1] && (av != '0);
            end else begin
                n_c.c.neg[i] = av[qau_pkg::DW-1];
            end
            unique case (r_b.op)
                qau_pkg::OP_ADD: sr = qau_pkg::sat(qau_pkg::PW'(av) + qau_pkg::PW'(bv));
                qau_pkg::OP_NEG: sr = qau_pkg::sat(-qau_pkg::PW'(av));
                default:         sr = '0;
            endcase
            n_c.c.res[i] = sr[qau_pkg::DW-1:0];
            satany       = satany | sr[qau_pkg::DW];
        end
        n_c.c.st = satany ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (en) begin
            r_c <= n_c;
        end
    end

    // Stage D: round the products half up and saturate; seed the square root.
    always_comb begin
        logic signed [qau_pkg::PW-1:0] v;
        logic [qau_pkg::DW:0]          sr;
        logic                          satany;

        n_d      = '0;
        n_d.c    = r_c.c;
        satany   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            v      = ($signed(r_c.ps[i]) + qau_pkg::HALF) >>> qau_pkg::FRAC_BITS;
            sr     = qau_pkg::sat(v);
            satany = satany | sr[qau_pkg::DW];
            if (r_c.c.op == qau_pkg::OP_MUL) begin
                n_d.c.res[i] = sr[qau_pkg::DW-1:0];
            end
        end
        if (r_c.c.op == qau_pkg::OP_MUL) begin
            n_d.c.st = satany ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0] <= '0;
        end else if (en) begin
            r_sq[0] <= n_d;
        end
    end

    // Square root of the squared magnitude with EXT extra fraction bits,
    // resolved one root bit per stage, most significant first.
    for (genvar k = 0; k < qau_pkg::RT_STEPS; k++) begin : g_sqrt
        qau_pkg::t_sqs            n_s;
        logic [qau_pkg::XPW-1:0]  x;
        logic [qau_pkg::RMW-1:0]  t;
        logic [qau_pkg::RMW-1:0]  trial;

        always_comb begin
            x     = qau_pkg::XPW'(r_sq[k].c.s) << (2 * qau_pkg::EXT);
            t     = {r_sq[k].rem[qau_pkg::RMW-3:0], x[qau_pkg::XPW-1-2*k -: 2]};
            trial = qau_pkg::RMW'({r_sq[k].root, 2'b01});
            n_s   = r_sq[k];
            if (t >= trial) begin
                n_s.rem  = t - trial;
                n_s.root = {r_sq[k].root[qau_pkg::RTW-2:0], 1'b1};
            end else begin
                n_s.rem  = t;
                n_s.root = {r_sq[k].root[qau_pkg::RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k+1] <= '0;
            end else if (en) begin
                r_sq[k+1] <= n_s;
            end
        end
    end

    // Division setup. Normalization divides the scaled magnitude plus half the
    // root by the root; the inverse divides the scaled magnitude by the squared
    // magnitude. A quotient that needs more than DQB bits always saturates.
    always_comb begin
        logic [qau_pkg::RTW-1:0] m;
        logic [qau_pkg::SW-1:0]  d;
        logic [qau_pkg::NW-1:0]  nn;
        logic [qau_pkg::CW-1:0]  r0;

        n_p   = '0;
        n_p.c = r_sq[qau_pkg::RT_STEPS].c;
        m     = r_sq[qau_pkg::RT_STEPS].root;
        if (n_p.c.op == qau_pkg::OP_INV) begin
            d = n_p.c.s;
        end else begin
            d = qau_pkg::SW'(m);
        end
        n_p.d = d;
        for (int i = 0; i < 4; i++) begin
            if (n_p.c.op == qau_pkg::OP_INV) begin
                nn = qau_pkg::NW'(n_p.c.mag[i]) << (2 * qau_pkg::FRAC_BITS + 1);
            end else begin
                nn = (qau_pkg::NW'(n_p.c.mag[i]) << (qau_pkg::FRAC_BITS + qau_pkg::EXT))
                   + qau_pkg::NW'(m >> 1);
            end
            r0           = qau_pkg::CW'(nn >> qau_pkg::DQB);
            n_p.ovf[i]   = r0 >= qau_pkg::CW'(d);
            n_p.rem[i]   = qau_pkg::SW'(r0);
            n_p.low[i]   = nn[qau_pkg::DQB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= '0;
        end else if (en) begin
            r_dv[0] <= n_p;
        end
    end

    // Restoring division, four lanes side by side, one quotient bit per stage.
    for (genvar k = 0; k < qau_pkg::DQB; k++) begin : g_div
        qau_pkg::t_dvs           n_v;
        logic [qau_pkg::SW:0]    t;
        logic                    qb;

        always_comb begin
            n_v = r_dv[k];
            t   = '0;
            qb  = 1'b0;
            for (int i = 0; i < 4; i++) begin
                t = {r_dv[k].rem[i], r_dv[k].low[i][qau_pkg::DQB-1-k]};
                if (t >= {1'b0, r_dv[k].d}) begin
                    n_v.rem[i] = qau_pkg::SW'(t - {1'b0, r_dv[k].d});
                    qb         = 1'b1;
                end else begin
                    n_v.rem[i] = t[qau_pkg::SW-1:0];
                    qb         = 1'b0;
                end
                n_v.q[i] = {r_dv[k].q[i][qau_pkg::DQB-2:0], qb};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= '0;
            end else if (en) begin
                r_dv[k+1] <= n_v;
            end
        end
    end

    // Output stage: inverse rounds half up, signs are applied, everything
    // saturates, and a zero magnitude overrides the division results.
    always_comb begin
        logic [qau_pkg::DQB:0]         qr;
        logic signed [qau_pkg::PW-1:0] v;
        logic [qau_pkg::DW:0]          sr;
        logic                          satany;
        logic [3:0][qau_pkg::DW-1:0]   dres;
        qau_pkg::t_dvs                 rd;

        rd        = r_dv[qau_pkg::DQB];
        n_out_vld = rd.c.vld;
        n_out_res = rd.c.res;
        n_out_st  = rd.c.st;
        satany    = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (rd.c.op == qau_pkg::OP_INV) begin
                qr = ((qau_pkg::DQB + 1)'(rd.q[i]) + 1'b1) >> 1;
            end else begin
                qr = (qau_pkg::DQB + 1)'(rd.q[i]);
            end
            v = qau_pkg::PW'(qr);
            if (rd.c.neg[i]) begin
                v = -v;
            end
            if (rd.ovf[i]) begin
                sr = {1'b1, rd.c.neg[i] ? qau_pkg::RMIN : qau_pkg::RMAX};
            end else begin
                sr = qau_pkg::sat(v);
            end
            dres[i] = sr[qau_pkg::DW-1:0];
            satany  = satany | sr[qau_pkg::DW];
        end
        if (rd.c.op == qau_pkg::OP_NRM || rd.c.op == qau_pkg::OP_INV) begin
            if (rd.c.s == '0) begin
                n_out_res = '0;
                n_out_st  = (rd.c.op == qau_pkg::OP_INV) ? qau_pkg::ST_INV0 : qau_pkg::ST_OK;
            end else begin
                n_out_res = dres;
                n_out_st  = satany ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_out_res <= '0;
            r_out_st  <= qau_pkg::ST_OK;
        end else if (en) begin
            r_out_vld <= n_out_vld;
            r_out_res <= n_out_res;
            r_out_st  <= n_out_st;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_r_w    = r_out_res[0];
    assign o_r_x    = r_out_res[1];
    assign o_r_y    = r_out_res[2];
    assign o_r_z    = r_out_res[3];
    assign o_status = r_out_st;

endmodule

@@ rtl/core/qau_checker.sv @@
module qau_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [qau_pkg::DW-1:0]  o_r_w,
    input logic [qau_pkg::DW-1:0]  o_r_x,
    input logic [qau_pkg::DW-1:0]  o_r_y,
    input logic [qau_pkg::DW-1:0]  o_r_z,
    input logic [1:0]              o_status
);

    // The unit only pushes back while it holds a result of its own.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_inv_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == qau_pkg::ST_INV0) |->
        (o_r_w == '0 && o_r_x == '0 && o_r_y == '0 && o_r_z == '0))
        else $error("inverse of zero gave a nonzero result");

    // A saturation flag must come with at least one clamped component.
    a_sat_has_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == qau_pkg::ST_SAT) |->
        (o_r_w == qau_pkg::RMAX || o_r_w == qau_pkg::RMIN ||
         o_r_x == qau_pkg::RMAX || o_r_x == qau_pkg::RMIN ||
         o_r_y == qau_pkg::RMAX || o_r_y == qau_pkg::RMIN ||
         o_r_z == qau_pkg::RMAX || o_r_z == qau_pkg::RMIN))
        else $error("saturation flagged without a clamped component");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_r_w) && $stable(o_r_x) && $stable(o_r_y) &&
         $stable(o_r_z) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);
